// File: rtl/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg: shared types and constants
// widths, register codes and side-band structs for the spring force pipeline
// ----------------------------------------------------------------------------
package sfd_pkg;

	// coordinate and fixed point format
	localparam int COORD_W   = 32;
	localparam int FRAC_BITS = 16;
	localparam int UNIT_BITS = 30;
	localparam int CFG_W     = 32;
	localparam int OUT_W     = 32;

	// derived widths
	localparam int DIFF_W  = COORD_W + 1;
	localparam int MAG_W   = DIFF_W;
	localparam int SUM_W   = 2 * MAG_W;
	localparam int LEN_W   = MAG_W;
	localparam int RD_W    = LEN_W + 1;
	localparam int P_W     = CFG_W + LEN_W;
	localparam int FMAG_W  = P_W - FRAC_BITS;
	localparam int Q_W     = UNIT_BITS + 1;
	localparam int R_W     = LEN_W + 1;
	localparam int FL_W    = 31;
	localparam int FH_W    = FMAG_W - FL_W;
	localparam int PH_W    = FH_W + Q_W;
	localparam int PL_W    = FL_W + Q_W;
	localparam int PROD_W  = FMAG_W + Q_W;

	localparam logic [CFG_W-1:0] STIFF_RESET = CFG_W'(65536);
	localparam logic [CFG_W-1:0] REST_RESET  = '0;

	// configuration register codes
	typedef enum logic [0:0] {
		REG_REST_LENGTH = 1'b0,
		REG_STIFFNESS   = 1'b1
	} cfg_reg_t;

	// difference vector magnitudes and signs
	typedef struct packed {
		logic [2:0]            neg;
		logic [2:0][MAG_W-1:0] mag;
	} vec_t;

	// side data that rides along the divider
	typedef struct packed {
		logic              coinc;
		logic              fneg;
		logic [2:0]        neg;
		logic [FMAG_W-1:0] fmag;
	} div_side_t;

endpackage

// File: rtl/spring_force_3d_top.sv
// ----------------------------------------------------------------------------
// spring_force_3d_top: Hooke spring force on one end of a 3D spring
// difference, squared length, square root, scalar force, unit vector, scale
// ----------------------------------------------------------------------------
// path: front stages s1-s4, sqrt, force stages s5-s7, divider, then the output stages
// throughput: one beat per cycle while the output is not stalled, set by the one-bit-per-stage sqrt and divider
// the whole pipeline advances when the output register is empty or taken
// reset: arst_n clears all valid bits; rest_length to 0, stiffness to 1.0
// ----------------------------------------------------------------------------
module spring_force_3d_top import sfd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	// configuration write
	input  logic         cfg_we,
	input  logic [0:0]   cfg_idx,
	input  logic [31:0]  cfg_wdata,
	// input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	// self_x, self_y, self_z, other_x, other_y, other_z
	input  logic [191:0] s_tdata,
	// output stream
	output logic         m_tvalid,
	input  logic         m_tready,
	// force_x, force_y, force_z
	output logic [95:0]  m_tdata,
	// coincident, saturated
	output logic [1:0]   m_tuser
);

	logic [CFG_W-1:0] rest_q;
	logic [CFG_W-1:0] stiff_q;
	logic             en;

	logic                   vld_s1, vld_s2, vld_s3, vld_s4;
	logic [2:0][DIFF_W-1:0] dif_s1;
	vec_t                   vec_s2, vec_s3, vec_s4;
	logic [2:0][SUM_W-1:0]  sq_s3;
	logic [SUM_W-1:0]       sum_s4;

	logic             sq_vld;
	logic [LEN_W-1:0] root;
	vec_t             sq_side;

	logic             vld_s5, vld_s6, vld_s7;
	logic [RD_W-1:0]  rdif_s5;
	logic [LEN_W-1:0] len_s5, len_s6, len_s7;
	vec_t             vec_s5, vec_s6, vec_s7;
	logic             fneg_s6, fneg_s7;
	logic [LEN_W-1:0] dmag_s6;
	logic [P_W-1:0]   p_s7;
	div_side_t        dv_side;

	logic                dv_vld;
	logic [2:0][Q_W-1:0] quo;
	div_side_t           dv_out_side;

	logic [2:0][OUT_W-1:0] frc;
	logic                  coinc;
	logic                  sat;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rest_q  <= REST_RESET;
			stiff_q <= STIFF_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_REST_LENGTH: rest_q  <= cfg_wdata;
				REG_STIFFNESS:   stiff_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// global advance
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// valid chain of the front stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// difference, magnitude, squares, sum of squares
	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				dif_s1[l] <= {s_tdata[(l+3)*COORD_W + COORD_W-1], s_tdata[(l+3)*COORD_W +: COORD_W]}
					- {s_tdata[l*COORD_W + COORD_W-1], s_tdata[l*COORD_W +: COORD_W]};
				vec_s2.neg[l] <= dif_s1[l][DIFF_W-1];
				vec_s2.mag[l] <= dif_s1[l][DIFF_W-1] ? -dif_s1[l] : dif_s1[l];
				sq_s3[l]      <= vec_s2.mag[l] * vec_s2.mag[l];
			end
			vec_s3 <= vec_s2;
			sum_s4 <= sq_s3[0] + sq_s3[1] + sq_s3[2];
			vec_s4 <= vec_s3;
		end
	end

	sfd_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s4),
		.rad      (sum_s4),
		.in_side  (vec_s4),
		.out_vld  (sq_vld),
		.root     (root),
		.out_side (sq_side)
	);

	// scalar force stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s5 <= sq_vld;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rdif_s5 <= {1'b0, root} - RD_W'(rest_q);
			len_s5  <= root;
			vec_s5  <= sq_side;
			fneg_s6 <= rdif_s5[RD_W-1];
			dmag_s6 <= rdif_s5[RD_W-1] ? LEN_W'(-rdif_s5) : rdif_s5[LEN_W-1:0];
			len_s6  <= len_s5;
			vec_s6  <= vec_s5;
			p_s7    <= stiff_q * dmag_s6;
			fneg_s7 <= fneg_s6;
			len_s7  <= len_s6;
			vec_s7  <= vec_s6;
		end
	end

	always_comb begin
		dv_side.coinc = (len_s7 == '0);
		dv_side.fneg  = fneg_s7;
		dv_side.neg   = vec_s7.neg;
		dv_side.fmag  = p_s7[FRAC_BITS +: FMAG_W];
	end

	sfd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s7),
		.len      (len_s7),
		.num      (vec_s7.mag),
		.in_side  (dv_side),
		.out_vld  (dv_vld),
		.quo      (quo),
		.out_side (dv_out_side)
	);

	sfd_out u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (dv_vld),
		.quo     (quo),
		.in_side (dv_out_side),
		.out_vld (m_tvalid),
		.frc     (frc),
		.coinc   (coinc),
		.sat     (sat)
	);

	assign m_tdata = frc;
	assign m_tuser = {sat, coinc};

endmodule

// File: rtl/sfd_sqrt.sv
// ----------------------------------------------------------------------------
// sfd_sqrt: pipelined integer square root
// one result bit per stage, remainder kept as radicand minus root squared
// ----------------------------------------------------------------------------
module sfd_sqrt import sfd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_vld,
	input  logic [SUM_W-1:0] rad,
	input  vec_t             in_side,
	output logic             out_vld,
	output logic [LEN_W-1:0] root,
	output vec_t             out_side
);

	logic             vld_s  [0:LEN_W];
	logic [SUM_W-1:0] rem_s  [0:LEN_W];
	logic [LEN_W-1:0] res_s  [0:LEN_W];
	vec_t             side_s [0:LEN_W];

	// stage entry
	assign vld_s[0]  = in_vld;
	assign rem_s[0]  = rad;
	assign res_s[0]  = '0;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < LEN_W; k++) begin : g_stage
		localparam int B = LEN_W - 1 - k;
		logic [SUM_W:0] trial;
		logic           take;

		// trial is (2*res + 2^B) * 2^B
		always_comb begin
			trial = ({{(SUM_W+1-LEN_W){1'b0}}, res_s[k]} << (B + 1))
				+ ((SUM_W+1)'(1) << (2 * B));
			take  = ({1'b0, rem_s[k]} >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k+1] <= 1'b0;
			else if (en)
				vld_s[k+1] <= vld_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= take ? (rem_s[k] - trial[SUM_W-1:0]) : rem_s[k];
				res_s[k+1]  <= take ? (res_s[k] | (LEN_W'(1) << B)) : res_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_vld  = vld_s[LEN_W];
	assign root     = res_s[LEN_W];
	assign out_side = side_s[LEN_W];

endmodule

// File: rtl/sfd_div.sv
// ----------------------------------------------------------------------------
// sfd_div: pipelined three lane restoring divider
// forms floor(num * 2^UNIT_BITS / len), one quotient bit per stage
// ----------------------------------------------------------------------------
module sfd_div import sfd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_vld,
	input  logic [LEN_W-1:0]      len,
	input  logic [2:0][MAG_W-1:0] num,
	input  div_side_t             in_side,
	output logic                  out_vld,
	output logic [2:0][Q_W-1:0]   quo,
	output div_side_t             out_side
);

	logic                  vld_s  [0:Q_W];
	logic [LEN_W-1:0]      len_s  [0:Q_W];
	logic [2:0][R_W-1:0]   r_s    [0:Q_W];
	logic [2:0][Q_W-1:0]   q_s    [0:Q_W];
	div_side_t             side_s [0:Q_W];

	// stage entry
	assign vld_s[0]  = in_vld;
	assign len_s[0]  = len;
	assign side_s[0] = in_side;
	for (genvar l = 0; l < 3; l++) begin : g_entry
		assign r_s[0][l] = {1'b0, num[l]};
		assign q_s[0][l] = '0;
	end

	for (genvar k = 0; k < Q_W; k++) begin : g_stage
		logic [2:0][R_W-1:0] sh;
		logic [2:0]          ge;

		// first step compares without a shift, the rest shift the remainder
		for (genvar l = 0; l < 3; l++) begin : g_lane
			if (k == 0) begin : g_first
				assign sh[l] = r_s[k][l];
			end else begin : g_next
				assign sh[l] = {r_s[k][l][R_W-2:0], 1'b0};
			end
			assign ge[l] = (sh[l] >= {1'b0, len_s[k]});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k+1] <= 1'b0;
			else if (en)
				vld_s[k+1] <= vld_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < 3; l++) begin
					r_s[k+1][l] <= ge[l] ? (sh[l] - {1'b0, len_s[k]}) : sh[l];
					q_s[k+1][l] <= {q_s[k][l][Q_W-2:0], ge[l]};
				end
				len_s[k+1]  <= len_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_vld  = vld_s[Q_W];
	assign quo      = q_s[Q_W];
	assign out_side = side_s[Q_W];

endmodule

// File: rtl/sfd_out.sv
// ----------------------------------------------------------------------------
// sfd_out: force component scaling and saturation
// split multiply of scalar force by unit vector, then sign and clip
// ----------------------------------------------------------------------------
module sfd_out import sfd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_vld,
	input  logic [2:0][Q_W-1:0]   quo,
	input  div_side_t             in_side,
	output logic                  out_vld,
	output logic [2:0][OUT_W-1:0] frc,
	output logic                  coinc,
	output logic                  sat
);

	localparam logic [PROD_W-1:0] POS_MAX = PROD_W'(32'h7fff_ffff);
	localparam logic [PROD_W-1:0] NEG_MAX = PROD_W'(32'h8000_0000);

	logic                 vld_s1;
	logic [2:0][PH_W-1:0] ph_s1;
	logic [2:0][PL_W-1:0] pl_s1;
	div_side_t            side_s1;

	logic [2:0][PROD_W-1:0] m;
	logic [2:0][OUT_W-1:0]  val;
	logic [2:0]             clip;
	logic [2:0]             ngv;

	// partial products of scalar force and unit vector
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (en)
			vld_s1 <= in_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				ph_s1[l] <= in_side.fmag[FMAG_W-1:FL_W] * quo[l];
				pl_s1[l] <= in_side.fmag[FL_W-1:0] * quo[l];
			end
			side_s1 <= in_side;
		end
	end

	// recombine, apply sign and clip
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			m[l]    = ({ph_s1[l], {FL_W{1'b0}}} + PROD_W'(pl_s1[l])) >> UNIT_BITS;
			ngv[l]  = side_s1.neg[l] ^ side_s1.fneg;
			clip[l] = ngv[l] ? (m[l] > NEG_MAX) : (m[l] > POS_MAX);
			if (clip[l])
				val[l] = ngv[l] ? OUT_W'(32'h8000_0000) : OUT_W'(32'h7fff_ffff);
			else if (ngv[l])
				val[l] = -m[l][OUT_W-1:0];
			else
				val[l] = m[l][OUT_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld <= 1'b0;
		else if (en)
			out_vld <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (side_s1.coinc) begin
				frc   <= '0;
				coinc <= 1'b1;
				sat   <= 1'b0;
			end else begin
				frc   <= val;
				coinc <= 1'b0;
				sat   <= |clip;
			end
		end
	end

endmodule

// File: rtl/sfd_chk.sv
// ----------------------------------------------------------------------------
// sfd_chk: port level checks for the spring force block
// output flags against force values and handshake behavior
// ----------------------------------------------------------------------------
module sfd_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         cfg_we,
	input logic [0:0]   cfg_idx,
	input logic [31:0]  cfg_wdata,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [191:0] s_tdata,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [95:0]  m_tdata,
	input logic [1:0]   m_tuser
);

	// held beat stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output beat changed while stalled");

	// coincident ends give zero force and no clip
	a_coinc: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == 96'd0 && !m_tuser[1])
		else $error("coincident beat with nonzero force");

	// a clip shows as an extreme component
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |->
			m_tdata[31:0] == 32'h7fff_ffff || m_tdata[31:0] == 32'h8000_0000 ||
			m_tdata[63:32] == 32'h7fff_ffff || m_tdata[63:32] == 32'h8000_0000 ||
			m_tdata[95:64] == 32'h7fff_ffff || m_tdata[95:64] == 32'h8000_0000)
		else $error("saturated flag without a clipped component");

	// an empty output register never blocks the input
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

endmodule

bind spring_force_3d_top sfd_chk u_sfd_chk (.*);

// File: sim/tb_spring_force_3d_top.sv
// ----------------------------------------------------------------------------
// tb_spring_force_3d_top: self-checking bench for the spring force pipeline
// drives coordinate pairs through the stream port, predicts each force in
// wide integer arithmetic, and checks every output beat in order
// ----------------------------------------------------------------------------
module tb_spring_force_3d_top;
	import sfd_pkg::*;

	// one coordinate pair
	typedef struct {
		logic signed [31:0] sx, sy, sz, ox, oy, oz;
	} ends_t;

	// one predicted force
	typedef struct {
		logic [31:0] fx, fy, fz;
		logic        coinc, sat;
	} force_t;

	// force predictor and in-order checker
	class force_board;
		logic [31:0] rest_len;
		logic [31:0] stiff;
		force_t      pending[$];
		int          errors;
		int          n_checked;
		int          n_coinc;
		int          n_sat;

		function void reset_regs();
			rest_len = REST_RESET;
			stiff    = STIFF_RESET;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [31:0] v);
			if (idx == REG_REST_LENGTH) rest_len = v;
			else stiff = v;
		endfunction

		function logic [63:0] root_of(logic [127:0] n);
			logic [63:0]  r;
			logic [63:0]  c;
			logic [127:0] sq;
			r = 0;
			for (int i = 63; i >= 0; i--) begin
				c = r | (64'd1 << i);
				sq = 128'(c) * 128'(c);
				if (sq <= n) r = c;
			end
			return r;
		endfunction

		// one force component with saturation
		function logic [31:0] scale_comp(logic [63:0] fmag, bit fneg,
				logic signed [33:0] d, logic [63:0] len, inout bit sat);
			logic [63:0]  dm;
			logic [63:0]  u;
			logic [127:0] m;
			bit           neg;
			dm = d < 0 ? 64'(-d) : 64'(d);
			u = (128'(dm) << 30) / 128'(len);
			m = (128'(fmag) * 128'(u)) >> 30;
			neg = (d < 0) != fneg;
			if (!neg) begin
				if (m > 128'h7FFF_FFFF) begin
					sat = 1;
					return 32'h7FFF_FFFF;
				end
				return m[31:0];
			end
			if (m > 128'h8000_0000) begin
				sat = 1;
				return 32'h8000_0000;
			end
			return -m[31:0];
		endfunction

		function void note_input(ends_t e);
			logic signed [33:0] dx, dy, dz;
			logic [127:0]       sumsq;
			logic [63:0]        len;
			logic signed [65:0] dl;
			logic [127:0]       p;
			logic [63:0]        fmag;
			bit                 fneg, sat;
			force_t             f;
			dx = 34'(e.ox) - 34'(e.sx);
			dy = 34'(e.oy) - 34'(e.sy);
			dz = 34'(e.oz) - 34'(e.sz);
			sumsq = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy) + 128'(dz) * 128'(dz);
			len = root_of(sumsq);
			f = '{default: 0};
			sat = 0;
			if (len == 0) begin
				f.coinc = 1;
			end else begin
				dl = 66'(len) - 66'(rest_len);
				fneg = dl < 0;
				p = (128'(stiff) * 128'(fneg ? -dl : dl)) >> FRAC_BITS;
				fmag = p > (128'd1 << 62) ? (64'd1 << 62) : p[63:0];
				f.fx = scale_comp(fmag, fneg, dx, len, sat);
				f.fy = scale_comp(fmag, fneg, dy, len, sat);
				f.fz = scale_comp(fmag, fneg, dz, len, sat);
				f.sat = sat;
			end
			pending.push_back(f);
		endfunction

		function void check_result(logic [95:0] data, logic [1:0] user);
			force_t f;
			logic [31:0] got[3];
			logic [31:0] want[3];
			if (pending.size() == 0) begin
				$display("%0t: unexpected force beat %h %b", $time, data, user);
				errors++;
				return;
			end
			f = pending.pop_front();
			n_checked++;
			if (f.coinc) n_coinc++;
			if (f.sat) n_sat++;
			got = '{data[31:0], data[63:32], data[95:64]};
			want = '{f.fx, f.fy, f.fz};
			for (int i = 0; i < 3; i++)
				if (got[i] !== want[i]) begin
					$display("%0t: force[%0d] expected %h actual %h",
						$time, i, want[i], got[i]);
					errors++;
				end
			if (user[0] !== f.coinc) begin
				$display("%0t: coincident expected %b actual %b", $time, f.coinc, user[0]);
				errors++;
			end
			if (user[1] !== f.sat) begin
				$display("%0t: saturated expected %b actual %b", $time, f.sat, user[1]);
				errors++;
			end
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [0:0]   cfg_idx;
	logic [31:0]  cfg_wdata;
	logic         s_tvalid;
	logic         s_tready;
	logic [191:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [95:0]  m_tdata;
	logic [1:0]   m_tuser;

	force_board board;
	bit         quiet_in;
	bit         quiet_out;
	bit         done;

	spring_force_3d_top u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready),
		.m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// run limit
	initial begin
		#20_000_000;
		$display("FAILURE");
		$finish;
	end

	// output side: random stalls, check each beat
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_result(m_tdata, m_tuser);
		m_tready <= quiet_out ? 1'b1 : ($urandom_range(99) >= 13);
	end

	// one register write, with the write enable dropped again before the task returns
	task automatic write_reg(cfg_reg_t idx, logic [31:0] v);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.write_reg(idx, v);
		@(posedge clk);
	endtask

	// one input beat, with random idle cycles ahead of it
	task automatic send_ends(ends_t e);
		while (!quiet_in && $urandom_range(99) < 13) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {e.oz, e.oy, e.ox, e.sz, e.sy, e.sx};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		board.note_input(e);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord(int mode);
		case (mode)
			0: return $urandom;
			1: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
			2: return $urandom_range(32'h0100_0000) - 32'h0080_0000;
			default: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
		endcase
	endfunction

	function automatic ends_t rand_ends();
		ends_t e;
		int    mode;
		mode = $urandom_range(3);
		e.sx = rand_coord(mode); e.sy = rand_coord(mode); e.sz = rand_coord(mode);
		e.ox = rand_coord(mode); e.oy = rand_coord(mode); e.oz = rand_coord(mode);
		// sometimes coincident, one-axis or two-axis springs
		case ($urandom_range(19))
			0: e = '{e.sx, e.sy, e.sz, e.sx, e.sy, e.sz};
			1: begin e.oy = e.sy; e.oz = e.sz; end
			2: e.ox = e.sx;
			default: ;
		endcase
		return e;
	endfunction

	localparam logic [31:0] MAXP = 32'h7FFF_FFFF;
	localparam logic [31:0] MINN = 32'h8000_0000;

	// stimulus
	initial begin
		ends_t       e;
		logic [31:0] rl[6];
		logic [31:0] kk[6];
		board = new();
		board.reset_regs();
		arst_n = 1'b0;
		cfg_we = 1'b0; cfg_idx = '0; cfg_wdata = '0;
		s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b0;
		quiet_in = 0; quiet_out = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed beats under reset registers
		send_ends('{0, 0, 0, 0, 0, 0});
		send_ends('{MAXP, 5, -7, MAXP, 5, -7});
		send_ends('{0, 0, 0, 32'h0001_0000, 0, 0});
		send_ends('{0, 0, 0, 0, -32'sh0003_0000, 0});
		send_ends('{0, 0, 0, 0, 0, 1});
		send_ends('{MINN, MINN, MINN, MAXP, MAXP, MAXP});
		send_ends('{MAXP, MAXP, MAXP, MINN, MINN, MINN});
		send_ends('{MAXP, MINN, 0, MINN, MAXP, 32'hFFFF_FFFF});
		send_ends('{32'h0001_0000, 32'h0002_0000, 32'h0002_0000, 0, 0, 0});
		drain();

		// compressed, resting, stretched and coincident springs, huge stiffness
		write_reg(REG_REST_LENGTH, 32'h0005_0000);
		write_reg(REG_STIFFNESS, 32'hFFFF_FFFF);
		send_ends('{0, 0, 0, 32'h0001_0000, 0, 0});
		send_ends('{0, 0, 0, 0, 0, 32'h0005_0000});
		send_ends('{0, 0, 0, 32'h0003_0000, 32'h0004_0000, 0});
		send_ends('{MINN, 0, 0, MAXP, 0, 0});
		send_ends('{1, 2, 3, 1, 2, 3});
		drain();
		write_reg(REG_REST_LENGTH, 32'hFFFF_FFFF);
		write_reg(REG_STIFFNESS, 32'h0);
		send_ends('{0, 0, 0, 32'h0001_0000, 0, 0});
		send_ends('{MINN, MINN, MINN, MAXP, MAXP, MAXP});
		drain();

		// random phases over register settings, extremes included
		rl = '{32'h0, 32'hFFFF_FFFF, 32'h0001_0000, $urandom, $urandom_range(32'h0010_0000), 0};
		kk = '{32'hFFFF_FFFF, 32'h0, 32'h0000_0001, $urandom, 32'h0001_0000,
			$urandom_range(32'h0010_0000)};
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_REST_LENGTH, rl[ph]);
			write_reg(REG_STIFFNESS, kk[ph]);
			quiet_in = (ph == 2);
			quiet_out = (ph == 2);
			for (int i = 0; i < 180; i++) begin
				send_ends(rand_ends());
				// hold off until the pipeline empties
				if (i == 90) begin
					s_tvalid <= 1'b0;
					while (board.pending.size() != 0) @(posedge clk);
				end
			end
			drain();
		end
		quiet_in = 0;
		quiet_out = 0;
		done = 1;
	end

	// end of run
	initial begin
		wait (done);
		$display("checked %0d force beats, %0d coincident, %0d saturated",
			board.n_checked, board.n_coinc, board.n_sat);
		$display("six register settings plus directed ends, random stalls on both sides");
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/sfd_pkg.sv
rtl/sfd_sqrt.sv
rtl/sfd_div.sv
rtl/sfd_out.sv
rtl/spring_force_3d_top.sv
rtl/sfd_chk.sv
sim/tb_spring_force_3d_top.sv
